FILE: src/safb_pkg.sv
// safb_pkg: shared types, constants and helper functions for the
// advertisement frame builder. No dependencies.
`timescale 1ns / 1ps
package safb_pkg;

  localparam int SAFB_ANGLE_ITERATIONS = 20;
  localparam int ATAN_DEPTH = 32;
  localparam int ITER_W = 5;        // iteration counter, covers up to 32 iterations
  localparam int FRAME_LEN = 60;
  localparam int BYTE_IDX_W = 6;

  localparam int IN_TDATA_W = 168;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // CORDIC working widths
  localparam int CW = 32;
  // integer root: 56-bit radicand, 28-bit root
  localparam int RAD_W = 56;
  localparam int ROOT_W = 28;
  localparam int REM_W = 31;
  localparam int SQRT_STEPS = 28;
  localparam int SQRT_CNT_W = 5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATTERY_LOW      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FW_MAJOR         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FW_MINOR         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FW_PATCH         = 3'd4;

  // frame header and object ids
  localparam logic [7:0] HDR_0        = 8'hD2;
  localparam logic [7:0] HDR_1        = 8'hFC;
  localparam logic [7:0] HDR_2        = 8'h44;
  localparam logic [7:0] OBJ_COUNTER  = 8'h00;
  localparam logic [7:0] ID_BATT_PCT  = 8'h01;
  localparam logic [7:0] OBJ_TEMP     = 8'h02;
  localparam logic [7:0] ID_MILLIVOLT = 8'h0C;
  localparam logic [7:0] OBJ_GENERIC  = 8'h0F;
  localparam logic [7:0] OBJ_LOW_BATT = 8'h15;
  localparam logic [7:0] OBJ_CO       = 8'h16;
  localparam logic [7:0] ID_MOTION    = 8'h21;
  localparam logic [7:0] ID_MOVING    = 8'h22;
  localparam logic [7:0] OBJ_OBJ2B    = 8'h2B;
  localparam logic [7:0] OBJ_OBJ2C    = 8'h2C;
  localparam logic [7:0] ID_PRESS     = 8'h3A;
  localparam logic [7:0] ID_TILT      = 8'h3F;
  localparam logic [7:0] OBJ_ACCEL    = 8'h51;
  localparam logic [7:0] OBJ_GYRO     = 8'h52;
  localparam logic [7:0] OBJ_FIRMWARE = 8'hF2;

  typedef struct packed {
    logic                  load;
    logic                  prep;
    logic                  roll_start;
    logic                  sqrt_start;
    logic                  take_roll;
    logic                  pitch_start;
    logic [BYTE_IDX_W-1:0] byte_idx;
  } safb_cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic sqrt_busy;
  } safb_sts_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [21:0] atan_lut(input logic [ITER_W-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0: r = 22'd2949120;
      5'd1: r = 22'd1740967;
      5'd2: r = 22'd919879;
      5'd3: r = 22'd466945;
      5'd4: r = 22'd234379;
      5'd5: r = 22'd117304;
      5'd6: r = 22'd58666;
      5'd7: r = 22'd29335;
      5'd8: r = 22'd14668;
      5'd9: r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // |v| saturated to 16 bits
  function automatic logic [15:0] sat_mag(input logic signed [23:0] v);
    logic [23:0] a;
    a = v[23] ? 24'(-v) : 24'(v);
    return (a[23:16] != 8'd0) ? 16'hFFFF : a[15:0];
  endfunction

endpackage

FILE: src/sensor_advert_frame_builder.sv
// One sample in, one 60-byte frame out. After an item is taken, the prepare and
// start states set up, then the 28-step root runs with roll alongside, a state
// starts pitch, and the pitch iterations run. Then 60 bytes go out at one per
// cycle while m_tready is high; the next item is taken only after the last byte.
// Synchronous active-high reset restores register defaults, clears counter and
// previous-sample state.
`timescale 1ns / 1ps
module sensor_advert_frame_builder import safb_pkg::*; #(
  parameter int ANGLE_ITERATIONS = SAFB_ANGLE_ITERATIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, die_temperature,
  // battery_millivolts; four zero pad bits on top
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // frame_byte
  output logic                   m_tlast,   // frame_last
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  safb_cmd_t cmd;
  safb_sts_t sts;

  safb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  safb_datapath #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .frame_byte (m_tdata)
  );

endmodule

FILE: src/safb_cordic.sv
// safb_cordic: iterative vectoring CORDIC, one iteration per cycle,
// returns atan2 in tenths of a degree. Depends on safb_pkg.
`timescale 1ns / 1ps
module safb_cordic import safb_pkg::*; #(
  parameter int ANGLE_ITERATIONS = SAFB_ANGLE_ITERATIONS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [CW-1:0] x_in,
  output logic                 busy,
  output logic signed [15:0]   angle
);

  localparam logic [ITER_W-1:0] LastIter = ITER_W'(ANGLE_ITERATIONS - 1);

  logic signed [CW-1:0] x, y, z;
  logic [ITER_W-1:0]    cnt;
  logic signed [CW-1:0] xs, ys, da, z10, z_rnd;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign da = CW'(atan_lut(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LastIter) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quarter-turn pre-rotation for the left half plane
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x <= y_in;
          y <= -x_in;
          z <= CW'(90 * 65536);
        end else begin
          x <= -y_in;
          y <= x_in;
          z <= -CW'(90 * 65536);
        end
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + da;
      end else if (y < 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - da;
      end
    end
  end

  // z * 10 / 65536, truncated toward zero
  assign z10   = (z <<< 3) + (z <<< 1);
  assign z_rnd = z10[CW-1] ? (z10 + CW'(65535)) : z10;
  assign angle = 16'(z_rnd >>> 16);

endmodule

FILE: src/safb_isqrt.sv
// safb_isqrt: floor integer square root, two radicand bits per cycle.
// Depends on safb_pkg.
`timescale 1ns / 1ps
module safb_isqrt import safb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam logic [SQRT_CNT_W-1:0] LastStep = SQRT_CNT_W'(SQRT_STEPS - 1);

  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [SQRT_CNT_W-1:0] cnt;
  logic [REM_W-1:0]      rem_sh, trial;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LastStep) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/safb_datapath.sv
// safb_datapath: sample registers, configuration, motion and battery math,
// shared CORDIC unit, root unit, frame byte selection.
// Depends on safb_pkg, safb_cordic, safb_isqrt.
`timescale 1ns / 1ps
module safb_datapath import safb_pkg::*; #(
  parameter int ANGLE_ITERATIONS = SAFB_ANGLE_ITERATIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  safb_cmd_t              cmd,
  output safb_sts_t              sts,
  output logic [7:0]             frame_byte
);

  logic [15:0] motion_threshold;
  logic [6:0]  battery_low_percent;
  logic [7:0]  firmware_major, firmware_minor, firmware_patch;

  logic signed [19:0] accel_x, accel_y, accel_z;
  logic signed [23:0] rate_x, rate_y, rate_z;
  logic [15:0]        die_temperature, battery_millivolts;

  logic [7:0]         packet_counter;
  logic signed [19:0] prev_x, prev_y, prev_z;
  logic               sample_seen;
  logic               moved;
  logic [6:0]         pct;
  logic               low;
  logic [39:0]        sq_y, sq_z;
  logic signed [15:0] roll;
  logic               cordic_busy, sqrt_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold    <= 16'd300;
      battery_low_percent <= 7'd15;
      firmware_major      <= 8'd0;
      firmware_minor      <= 8'd1;
      firmware_patch      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOTION_THRESHOLD: motion_threshold    <= cfg_data;
        CFG_BATTERY_LOW:      battery_low_percent <= cfg_data[6:0];
        CFG_FW_MAJOR:         firmware_major      <= cfg_data[7:0];
        CFG_FW_MINOR:         firmware_minor      <= cfg_data[7:0];
        CFG_FW_PATCH:         firmware_patch      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accel_x            <= in_data[19:0];
      accel_y            <= in_data[39:20];
      accel_z            <= in_data[59:40];
      rate_x             <= in_data[83:60];
      rate_y             <= in_data[107:84];
      rate_z             <= in_data[131:108];
      die_temperature    <= in_data[147:132];
      battery_millivolts <= in_data[163:148];
    end
  end

  // motion: summed |delta| against the stored previous sample
  logic signed [20:0] dx, dy, dz;
  logic [20:0]        adx, ady, adz;
  logic [22:0]        dsum;
  assign dx   = 21'(accel_x) - 21'(prev_x);
  assign dy   = 21'(accel_y) - 21'(prev_y);
  assign dz   = 21'(accel_z) - 21'(prev_z);
  assign adx  = dx[20] ? 21'(-dx) : 21'(dx);
  assign ady  = dy[20] ? 21'(-dy) : 21'(dy);
  assign adz  = dz[20] ? 21'(-dz) : 21'(dz);
  assign dsum = 23'(adx) + 23'(ady) + 23'(adz);

  // battery curve; most per-segment divides done by reciprocal multiply, one by shift
  logic [15:0] seg_base;
  logic [15:0] d16;
  logic [8:0]  d;
  logic [16:0] prod;
  logic [6:0]  pct_c;
  always_comb begin
    if (battery_millivolts >= 16'd4000)      seg_base = 16'd4000;
    else if (battery_millivolts >= 16'd3800) seg_base = 16'd3800;
    else if (battery_millivolts >= 16'd3700) seg_base = 16'd3700;
    else if (battery_millivolts >= 16'd3500) seg_base = 16'd3500;
    else if (battery_millivolts >= 16'd3400) seg_base = 16'd3400;
    else                                     seg_base = 16'd3000;
    d16  = battery_millivolts - seg_base;
    d    = d16[8:0];
    prod = 17'(d) * 17'd205;   // prod >> 11 is d / 10 for d below 1029
    if (battery_millivolts >= 16'd4200)      pct_c = 7'd100;
    else if (battery_millivolts <= 16'd3000) pct_c = 7'd0;
    else if (battery_millivolts >= 16'd4000) pct_c = 7'd80 + 7'(prod[16:11]);
    else if (battery_millivolts >= 16'd3800) pct_c = 7'd55 + 7'(d[8:3]);
    else if (battery_millivolts >= 16'd3700) pct_c = 7'd35 + 7'(prod[16:10]);
    else if (battery_millivolts >= 16'd3500) pct_c = 7'd15 + 7'(prod[16:11]);
    else if (battery_millivolts >= 16'd3400) pct_c = 7'd5 + 7'(prod[16:11]);
    else                                     pct_c = 7'(prod[16:14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_counter <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      prev_z         <= '0;
      sample_seen    <= 1'b0;
    end else if (cmd.prep) begin
      packet_counter <= packet_counter + 8'd1;
      prev_x         <= accel_x;
      prev_y         <= accel_y;
      prev_z         <= accel_z;
      sample_seen    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      moved <= sample_seen && (dsum > 23'(motion_threshold));
      pct   <= pct_c;
      low   <= pct_c < battery_low_percent;
      sq_y  <= 40'(accel_y) * 40'(accel_y);
      sq_z  <= 40'(accel_z) * 40'(accel_z);
    end
  end

  // shared angle unit: roll first, then pitch from the root
  logic signed [CW-1:0] cy, cx;
  logic signed [15:0]   angle;
  logic [ROOT_W-1:0]    hyp;
  logic [RAD_W-1:0]     radicand;

  always_comb begin
    if (cmd.pitch_start) begin
      cy = -(CW'(accel_x) <<< 8);
      cx = CW'(hyp);
    end else begin
      cy = CW'(accel_y);
      cx = CW'(accel_z);
    end
  end

  assign radicand = {sq_y + sq_z, 16'd0};

  safb_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.roll_start | cmd.pitch_start),
    .y_in  (cy),
    .x_in  (cx),
    .busy  (cordic_busy),
    .angle (angle)
  );

  safb_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (hyp)
  );

  assign sts = '{cordic_busy: cordic_busy, sqrt_busy: sqrt_busy};

  always_ff @(posedge clk) begin
    if (cmd.take_roll) roll <= angle;
  end

  logic [15:0] m_ax, m_ay, m_az, m_rx, m_ry, m_rz;
  assign m_ax = sat_mag(24'(accel_x));
  assign m_ay = sat_mag(24'(accel_y));
  assign m_az = sat_mag(24'(accel_z));
  assign m_rx = sat_mag(rate_x);
  assign m_ry = sat_mag(rate_y);
  assign m_rz = sat_mag(rate_z);

  // pitch is read straight from the idle CORDIC while sending
  always_comb begin
    case (cmd.byte_idx)
      6'd0:  frame_byte = HDR_0;
      6'd1:  frame_byte = HDR_1;
      6'd2:  frame_byte = HDR_2;
      6'd3:  frame_byte = OBJ_COUNTER;
      6'd4:  frame_byte = packet_counter;
      6'd5:  frame_byte = ID_BATT_PCT;
      6'd6:  frame_byte = {1'b0, pct};
      6'd7:  frame_byte = OBJ_TEMP;
      6'd8:  frame_byte = die_temperature[7:0];
      6'd9:  frame_byte = die_temperature[15:8];
      6'd10: frame_byte = ID_MILLIVOLT;
      6'd11: frame_byte = battery_millivolts[7:0];
      6'd12: frame_byte = battery_millivolts[15:8];
      6'd13: frame_byte = OBJ_GENERIC;
      6'd14: frame_byte = {7'd0, moved};
      6'd15: frame_byte = OBJ_LOW_BATT;
      6'd16: frame_byte = {7'd0, low};
      6'd17: frame_byte = OBJ_CO;
      6'd19: frame_byte = ID_MOTION;
      6'd20: frame_byte = {7'd0, moved};
      6'd21: frame_byte = ID_MOVING;
      6'd22: frame_byte = {7'd0, moved};
      6'd23: frame_byte = OBJ_OBJ2B;
      6'd25: frame_byte = OBJ_OBJ2C;
      6'd27: frame_byte = ID_PRESS;
      6'd29: frame_byte = ID_TILT;
      6'd30: frame_byte = angle[7:0];
      6'd31: frame_byte = angle[15:8];
      6'd32: frame_byte = ID_TILT;
      6'd33: frame_byte = roll[7:0];
      6'd34: frame_byte = roll[15:8];
      6'd35: frame_byte = ID_TILT;
      6'd38: frame_byte = OBJ_ACCEL;
      6'd39: frame_byte = m_ax[7:0];
      6'd40: frame_byte = m_ax[15:8];
      6'd41: frame_byte = OBJ_ACCEL;
      6'd42: frame_byte = m_ay[7:0];
      6'd43: frame_byte = m_ay[15:8];
      6'd44: frame_byte = OBJ_ACCEL;
      6'd45: frame_byte = m_az[7:0];
      6'd46: frame_byte = m_az[15:8];
      6'd47: frame_byte = OBJ_GYRO;
      6'd48: frame_byte = m_rx[7:0];
      6'd49: frame_byte = m_rx[15:8];
      6'd50: frame_byte = OBJ_GYRO;
      6'd51: frame_byte = m_ry[7:0];
      6'd52: frame_byte = m_ry[15:8];
      6'd53: frame_byte = OBJ_GYRO;
      6'd54: frame_byte = m_rz[7:0];
      6'd55: frame_byte = m_rz[15:8];
      6'd56: frame_byte = OBJ_FIRMWARE;
      6'd57: frame_byte = firmware_patch;
      6'd58: frame_byte = firmware_minor;
      6'd59: frame_byte = firmware_major;
      default: frame_byte = 8'd0;   // zero-valued objects
    endcase
  end

endmodule

FILE: src/safb_ctrl.sv
// safb_ctrl: sequencer for one sample: prepare, roll and root, pitch,
// then stream the frame. Depends on safb_pkg.
`timescale 1ns / 1ps
module safb_ctrl import safb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output logic      m_tlast,
  input  safb_sts_t sts,
  output safb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_START1 = 3'd2;
  localparam logic [2:0] S_WAIT1  = 3'd3;
  localparam logic [2:0] S_START2 = 3'd4;
  localparam logic [2:0] S_WAIT2  = 3'd5;
  localparam logic [2:0] S_SEND   = 3'd6;

  localparam logic [BYTE_IDX_W-1:0] LastByte = BYTE_IDX_W'(FRAME_LEN - 1);

  logic [2:0]            state, state_next;
  logic [BYTE_IDX_W-1:0] idx;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SEND);
  assign m_tlast  = (idx == LastByte);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_PREP;
      S_PREP:   state_next = S_START1;
      S_START1: state_next = S_WAIT1;
      S_WAIT1:  if (!sts.cordic_busy && !sts.sqrt_busy) state_next = S_START2;
      S_START2: state_next = S_WAIT2;
      S_WAIT2:  if (!sts.cordic_busy) state_next = S_SEND;
      S_SEND:   if (m_tready && m_tlast) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SEND && m_tready) begin
        idx <= m_tlast ? '0 : idx + 1'b1;
      end
    end
  end

  always_comb begin
    cmd.load        = s_tvalid && s_tready;
    cmd.prep        = (state == S_PREP);
    cmd.roll_start  = (state == S_START1);
    cmd.sqrt_start  = (state == S_START1);
    cmd.take_roll   = (state == S_START2);
    cmd.pitch_start = (state == S_START2);
    cmd.byte_idx    = idx;
  end

endmodule
